[hw/rtl/hps_pkg.sv]
package hps_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int SAMPLE_BITS    = 32;
    localparam int RES_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Sized for the largest tile (256)
    localparam int TILE_BITS      = 8;
    localparam int CAP_BITS       = TILE_BITS + 1;
    localparam int EXP2_BITS      = 4;
    localparam int TERN_DIGITS    = 6;
    localparam int EXP3_BITS      = 3;
    localparam int POW3_BITS      = 10;
    localparam int STRIDE_BITS    = 18;
    localparam int OFFSET_BITS    = 18;

    localparam int SEQ_BITS       = 47;
    localparam int POFF_BITS      = 15;
    localparam int TILE_OUT_BITS  = 7;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RES_X = 2'd0,
        REG_RES_Y = 2'd1,
        REG_PERM2 = 2'd2,
        REG_PERM3 = 2'd3
    } cfg_reg_t;

    typedef logic [1:0] tdigit_t;

    typedef struct packed {
        logic                   unblocked;
        logic [EXP2_BITS-1:0]   exp2;
        logic [EXP3_BITS-1:0]   exp3;
        logic [POW3_BITS-1:0]   pow3;
        logic [TILE_BITS-1:0]   px_mask;
        logic [TILE_BITS-1:0]   inv_pow3;
        logic [STRIDE_BITS-1:0] stride;
        logic [1:0]             perm2;
        logic [5:0]             perm3;
    } hps_cfg_t;

    localparam hps_cfg_t CFG_RESET = '{
        unblocked: 1'b1,
        exp2:      '0,
        exp3:      '0,
        pow3:      10'd1,
        px_mask:   '0,
        inv_pow3:  '0,
        stride:    18'd1,
        perm2:     2'd2,
        perm3:     6'd36
    };

    function automatic logic [POW3_BITS-1:0] pow3(input logic [EXP3_BITS-1:0] e);
        logic [POW3_BITS-1:0] v;
        case (e)
            3'd0:    v = 10'd1;
            3'd1:    v = 10'd3;
            3'd2:    v = 10'd9;
            3'd3:    v = 10'd27;
            3'd4:    v = 10'd81;
            3'd5:    v = 10'd243;
            3'd6:    v = 10'd729;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

    // inverse of 3^e modulo 256
    function automatic logic [TILE_BITS-1:0] inv_pow3_mod(input logic [EXP3_BITS-1:0] e);
        logic [TILE_BITS-1:0] v;
        case (e)
            3'd0:    v = 8'd1;
            3'd1:    v = 8'd171;
            3'd2:    v = 8'd57;
            3'd3:    v = 8'd19;
            3'd4:    v = 8'd177;
            3'd5:    v = 8'd59;
            3'd6:    v = 8'd105;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    // exact floor(v / 3) for 8-bit v
    function automatic logic [TILE_BITS-1:0] div3(input logic [TILE_BITS-1:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

    function automatic tdigit_t perm_tern(input logic [5:0] perm, input tdigit_t d);
        tdigit_t v;
        case (d)
            2'd0:    v = perm[1:0];
            2'd1:    v = perm[3:2];
            2'd2:    v = perm[5:4];
            default: v = 2'd0;
        endcase
        return (v == 2'd3) ? 2'd2 : v;
    endfunction

endpackage

[hw/rtl/halton_pixel_sample_index.sv]
// Halton pixel sample index
//
// Command channel: present pixel_x, pixel_y and sample_index with start high;
// the command transfers at a rising edge where start is high and busy is low.
// busy stays low, so a new command can transfer on every clock.
// Result channel: done is high for exactly one cycle with sequence_index,
// pixel_offset, tile_x and tile_y; the result transfers at the edge ending
// that cycle. The receiver cannot stall the block.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects res_x,
// res_y, inv_perm_base2 or inv_perm_base3; cfg_ready is always high.
// Write configuration only while no command is in flight.
// Pipeline: 7 register stages (tile reduction 2, digit reversal 2, CRT
// combine and sample_index * stride 3). Throughput: one command per cycle.
// Reset: asynchronous, active low; empties the pipeline and sets res_x = 1,
// res_y = 1 and identity digit permutations.
module halton_pixel_sample_index #(
    parameter int TILE_SIZE         = 128,
    parameter int SAMPLE_INDEX_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hps_pkg::PIXEL_BITS-1:0]      pixel_x,
    input  logic [hps_pkg::PIXEL_BITS-1:0]      pixel_y,
    input  logic [hps_pkg::SAMPLE_BITS-1:0]     sample_index,
    output logic                                done,
    output logic [hps_pkg::SEQ_BITS-1:0]        sequence_index,
    output logic [hps_pkg::POFF_BITS-1:0]       pixel_offset,
    output logic [hps_pkg::TILE_OUT_BITS-1:0]   tile_x,
    output logic [hps_pkg::TILE_OUT_BITS-1:0]   tile_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import hps_pkg::*;

    hps_cfg_t                     cfg;
    logic                         cmd_valid;

    logic                         tm_valid;
    logic [TILE_BITS-1:0]         tm_tx;
    logic [TILE_BITS-1:0]         tm_ty;
    logic [SAMPLE_INDEX_BITS-1:0] tm_sample;

    logic                         dr_valid;
    logic [TILE_BITS-1:0]         dr_ox;
    logic [POW3_BITS-1:0]         dr_oy;
    logic [TILE_BITS-1:0]         dr_tx;
    logic [TILE_BITS-1:0]         dr_ty;
    logic [SAMPLE_INDEX_BITS-1:0] dr_sample;

    assign busy      = 1'b0;
    assign cmd_valid = start && !busy;

    hps_cfg_regs #(
        .TILE_SIZE (TILE_SIZE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hps_tile_mod #(
        .TILE_SIZE         (TILE_SIZE),
        .SAMPLE_INDEX_BITS (SAMPLE_INDEX_BITS)
    ) u_tile (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .sample_in  (sample_index[SAMPLE_INDEX_BITS-1:0]),
        .out_valid  (tm_valid),
        .tile_x     (tm_tx),
        .tile_y     (tm_ty),
        .sample_out (tm_sample)
    );

    hps_digit_rev #(
        .SAMPLE_INDEX_BITS (SAMPLE_INDEX_BITS)
    ) u_digit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (tm_valid),
        .tile_x_in  (tm_tx),
        .tile_y_in  (tm_ty),
        .sample_in  (tm_sample),
        .cfg        (cfg),
        .out_valid  (dr_valid),
        .ox         (dr_ox),
        .oy         (dr_oy),
        .tile_x_out (dr_tx),
        .tile_y_out (dr_ty),
        .sample_out (dr_sample)
    );

    hps_crt #(
        .SAMPLE_INDEX_BITS (SAMPLE_INDEX_BITS)
    ) u_crt (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (dr_valid),
        .ox             (dr_ox),
        .oy             (dr_oy),
        .tile_x_in      (dr_tx),
        .tile_y_in      (dr_ty),
        .sample_in      (dr_sample),
        .cfg            (cfg),
        .done           (done),
        .sequence_index (sequence_index),
        .pixel_offset   (pixel_offset),
        .tile_x         (tile_x),
        .tile_y         (tile_y)
    );

endmodule

[hw/rtl/hps_cfg_regs.sv]
module hps_cfg_regs #(
    parameter int TILE_SIZE = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output hps_pkg::hps_cfg_t                   cfg
);
    import hps_pkg::*;

    logic [RES_BITS-1:0] res_x_reg;
    logic [RES_BITS-1:0] res_y_reg;
    logic [1:0]          perm2_reg;
    logic [5:0]          perm3_reg;
    hps_cfg_t            cfg_reg;
    hps_cfg_t            cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg <= 16'd1;
            res_y_reg <= 16'd1;
            perm2_reg <= 2'd2;
            perm3_reg <= 6'd36;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RES_X: res_x_reg <= cfg_data;
                REG_RES_Y: res_y_reg <= cfg_data;
                REG_PERM2: perm2_reg <= cfg_data[1:0];
                REG_PERM3: perm3_reg <= cfg_data[5:0];
                default:   res_x_reg <= res_x_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [CAP_BITS-1:0]    cap_x;
        logic [CAP_BITS-1:0]    cap_y;
        logic [TILE_BITS-1:0]   below2;
        logic [TERN_DIGITS-1:0] below3;
        logic [STRIDE_BITS-1:0] stride;
        cap_x = (res_x_reg >= RES_BITS'(TILE_SIZE)) ? CAP_BITS'(TILE_SIZE)
                                                     : res_x_reg[CAP_BITS-1:0];
        cap_y = (res_y_reg >= RES_BITS'(TILE_SIZE)) ? CAP_BITS'(TILE_SIZE)
                                                     : res_y_reg[CAP_BITS-1:0];
        for (int e = 0; e < TILE_BITS; e++)
            below2[e] = (CAP_BITS'(1) << e) < cap_x;
        for (int e = 0; e < TERN_DIGITS; e++)
            below3[e] = pow3(EXP3_BITS'(e)) < POW3_BITS'(cap_y);
        cfg_next.exp2     = EXP2_BITS'($countones(below2));
        cfg_next.exp3     = EXP3_BITS'($countones(below3));
        cfg_next.pow3     = pow3(cfg_next.exp3);
        cfg_next.px_mask  = TILE_BITS'((CAP_BITS'(1) << cfg_next.exp2) - CAP_BITS'(1));
        cfg_next.inv_pow3 = inv_pow3_mod(cfg_next.exp3) & cfg_next.px_mask;
        stride            = STRIDE_BITS'(cfg_next.pow3) << cfg_next.exp2;
        cfg_next.unblocked = (res_x_reg == 16'd1) ||
                             (cfg_next.exp2 == '0 && cfg_next.exp3 == '0);
        cfg_next.stride   = cfg_next.unblocked ? STRIDE_BITS'(1) : stride;
        cfg_next.perm2    = perm2_reg;
        cfg_next.perm3    = perm3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    a_unblocked_stride: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.unblocked |-> cfg_reg.stride == STRIDE_BITS'(1))
        else $error("unblocked mode with stride other than one");

    a_stride_product: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_reg.unblocked |->
            cfg_reg.stride == (STRIDE_BITS'(cfg_reg.pow3) << cfg_reg.exp2))
        else $error("stride does not match axis powers");

endmodule

[hw/rtl/hps_tile_mod.sv]
module hps_tile_mod #(
    parameter int TILE_SIZE         = 128,
    parameter int SAMPLE_INDEX_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [hps_pkg::PIXEL_BITS-1:0]   pixel_x,
    input  logic [hps_pkg::PIXEL_BITS-1:0]   pixel_y,
    input  logic [SAMPLE_INDEX_BITS-1:0]     sample_in,
    output logic                             out_valid,
    output logic [hps_pkg::TILE_BITS-1:0]    tile_x,
    output logic [hps_pkg::TILE_BITS-1:0]    tile_y,
    output logic [SAMPLE_INDEX_BITS-1:0]     sample_out
);
    import hps_pkg::*;

    localparam int RECIP_SHIFT = 24;
    localparam int PROD_BITS   = PIXEL_BITS + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / TILE_SIZE);

    // quotient estimate is exact or one low
    function automatic logic [TILE_BITS-1:0] reduce(input logic [PIXEL_BITS-1:0] v,
                                                    input logic [PROD_BITS-1:0] prod);
        logic [PIXEL_BITS-1:0] q;
        logic [PROD_BITS-1:0]  qt;
        logic [PROD_BITS-1:0]  r;
        q  = prod[PROD_BITS-1 -: PIXEL_BITS];
        qt = PROD_BITS'(q) * PROD_BITS'(TILE_SIZE);
        r  = PROD_BITS'(v) - qt;
        if (r >= PROD_BITS'(TILE_SIZE))
            r = r - PROD_BITS'(TILE_SIZE);
        return r[TILE_BITS-1:0];
    endfunction

    logic                         v1_reg;
    logic [PIXEL_BITS-1:0]        x1_reg;
    logic [PIXEL_BITS-1:0]        y1_reg;
    logic [PROD_BITS-1:0]         px1_reg;
    logic [PROD_BITS-1:0]         py1_reg;
    logic [SAMPLE_INDEX_BITS-1:0] s1_reg;

    logic                         v2_reg;
    logic [TILE_BITS-1:0]         tx2_reg;
    logic [TILE_BITS-1:0]         ty2_reg;
    logic [SAMPLE_INDEX_BITS-1:0] s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= pixel_x;
        y1_reg  <= pixel_y;
        px1_reg <= PROD_BITS'(pixel_x) * PROD_BITS'(RECIP);
        py1_reg <= PROD_BITS'(pixel_y) * PROD_BITS'(RECIP);
        s1_reg  <= sample_in;
        tx2_reg <= reduce(x1_reg, px1_reg);
        ty2_reg <= reduce(y1_reg, py1_reg);
        s2_reg  <= s1_reg;
    end

    assign out_valid  = v2_reg;
    assign tile_x     = tx2_reg;
    assign tile_y     = ty2_reg;
    assign sample_out = s2_reg;

    a_tile_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (9'(tx2_reg) < 9'(TILE_SIZE)) && (9'(ty2_reg) < 9'(TILE_SIZE)))
        else $error("tile coordinate not reduced below tile size");

endmodule

[hw/rtl/hps_digit_rev.sv]
module hps_digit_rev #(
    parameter int SAMPLE_INDEX_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [hps_pkg::TILE_BITS-1:0]    tile_x_in,
    input  logic [hps_pkg::TILE_BITS-1:0]    tile_y_in,
    input  logic [SAMPLE_INDEX_BITS-1:0]     sample_in,
    input  hps_pkg::hps_cfg_t                cfg,
    output logic                             out_valid,
    output logic [hps_pkg::TILE_BITS-1:0]    ox,
    output logic [hps_pkg::POW3_BITS-1:0]    oy,
    output logic [hps_pkg::TILE_BITS-1:0]    tile_x_out,
    output logic [hps_pkg::TILE_BITS-1:0]    tile_y_out,
    output logic [SAMPLE_INDEX_BITS-1:0]     sample_out
);
    import hps_pkg::*;

    logic                         v3_reg;
    logic [TILE_BITS-1:0]         ox3_reg;
    logic [TILE_BITS-1:0]         ox3_next;
    tdigit_t                      pd3_reg  [TERN_DIGITS];
    tdigit_t                      pd3_next [TERN_DIGITS];
    logic [TILE_BITS-1:0]         tx3_reg;
    logic [TILE_BITS-1:0]         ty3_reg;
    logic [SAMPLE_INDEX_BITS-1:0] s3_reg;

    logic                         v4_reg;
    logic [TILE_BITS-1:0]         ox4_reg;
    logic [POW3_BITS-1:0]         oy4_reg;
    logic [POW3_BITS-1:0]         oy4_next;
    logic [TILE_BITS-1:0]         tx4_reg;
    logic [TILE_BITS-1:0]         ty4_reg;
    logic [SAMPLE_INDEX_BITS-1:0] s4_reg;

    // binary digits: mirror the full byte, then drop the digits above exp2
    always_comb
    begin
        logic [TILE_BITS-1:0] rev;
        logic [TILE_BITS-1:0] v;
        logic [TILE_BITS-1:0] q;
        logic [TILE_BITS-1:0] r;
        for (int i = 0; i < TILE_BITS; i++)
            rev[TILE_BITS-1-i] = cfg.perm2[tile_x_in[i]];
        ox3_next = rev >> (EXP2_BITS'(TILE_BITS) - cfg.exp2);
        v = tile_y_in;
        for (int i = 0; i < TERN_DIGITS; i++)
        begin
            q = div3(v);
            r = v - TILE_BITS'(q * 8'd3);
            pd3_next[i] = perm_tern(cfg.perm3, r[1:0]);
            v = q;
        end
    end

    always_comb
    begin
        logic [POW3_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < TERN_DIGITS; i++)
        begin
            if (EXP3_BITS'(i) < cfg.exp3)
                acc = acc + POW3_BITS'(pd3_reg[i]) *
                            pow3(EXP3_BITS'(cfg.exp3 - EXP3_BITS'(i) - EXP3_BITS'(1)));
        end
        oy4_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ox3_reg <= ox3_next;
        pd3_reg <= pd3_next;
        tx3_reg <= tile_x_in;
        ty3_reg <= tile_y_in;
        s3_reg  <= sample_in;
        ox4_reg <= ox3_reg;
        oy4_reg <= oy4_next;
        tx4_reg <= tx3_reg;
        ty4_reg <= ty3_reg;
        s4_reg  <= s3_reg;
    end

    assign out_valid  = v4_reg;
    assign ox         = ox4_reg;
    assign oy         = oy4_reg;
    assign tile_x_out = tx4_reg;
    assign tile_y_out = ty4_reg;
    assign sample_out = s4_reg;

    a_offsets_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (oy4_reg < cfg.pow3) && ((ox4_reg & ~cfg.px_mask) == '0))
        else $error("axis offset not below its axis power");

endmodule

[hw/rtl/hps_crt.sv]
module hps_crt #(
    parameter int SAMPLE_INDEX_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [hps_pkg::TILE_BITS-1:0]       ox,
    input  logic [hps_pkg::POW3_BITS-1:0]       oy,
    input  logic [hps_pkg::TILE_BITS-1:0]       tile_x_in,
    input  logic [hps_pkg::TILE_BITS-1:0]       tile_y_in,
    input  logic [SAMPLE_INDEX_BITS-1:0]        sample_in,
    input  hps_pkg::hps_cfg_t                   cfg,
    output logic                                done,
    output logic [hps_pkg::SEQ_BITS-1:0]        sequence_index,
    output logic [hps_pkg::POFF_BITS-1:0]       pixel_offset,
    output logic [hps_pkg::TILE_OUT_BITS-1:0]   tile_x,
    output logic [hps_pkg::TILE_OUT_BITS-1:0]   tile_y
);
    import hps_pkg::*;

    localparam int PS_BITS = SAMPLE_INDEX_BITS + STRIDE_BITS;

    logic                         v5_reg;
    logic [TILE_BITS-1:0]         t5_reg;
    logic [TILE_BITS-1:0]         t5_next;
    logic [POW3_BITS-1:0]         oy5_reg;
    logic [TILE_BITS-1:0]         tx5_reg;
    logic [TILE_BITS-1:0]         ty5_reg;
    logic [SAMPLE_INDEX_BITS-1:0] s5_reg;

    logic                         v6_reg;
    logic [OFFSET_BITS-1:0]       off6_reg;
    logic [PS_BITS-1:0]           ps6_reg;
    logic [TILE_BITS-1:0]         tx6_reg;
    logic [TILE_BITS-1:0]         ty6_reg;

    logic                         v7_reg;
    logic [SEQ_BITS-1:0]          seq7_reg;
    logic [POFF_BITS-1:0]         off7_reg;
    logic [TILE_OUT_BITS-1:0]     tx7_reg;
    logic [TILE_OUT_BITS-1:0]     ty7_reg;
    logic [63:0]                  seq_wide;

    // offset = oy + py * ((ox - oy) * py^-1 mod px)
    always_comb
    begin
        logic [TILE_BITS-1:0]   diff;
        logic [2*TILE_BITS-1:0] prod;
        diff    = ox - oy[TILE_BITS-1:0];
        prod    = (2*TILE_BITS)'(diff) * (2*TILE_BITS)'(cfg.inv_pow3);
        t5_next = prod[TILE_BITS-1:0] & cfg.px_mask;
    end

    assign seq_wide = 64'(ps6_reg) + 64'(off6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t5_reg   <= t5_next;
        oy5_reg  <= oy;
        tx5_reg  <= tile_x_in;
        ty5_reg  <= tile_y_in;
        s5_reg   <= sample_in;

        off6_reg <= cfg.unblocked ? '0
                  : OFFSET_BITS'(oy5_reg) + OFFSET_BITS'(cfg.pow3) * OFFSET_BITS'(t5_reg);
        ps6_reg  <= PS_BITS'(s5_reg) * PS_BITS'(cfg.stride);
        tx6_reg  <= cfg.unblocked ? '0 : tx5_reg;
        ty6_reg  <= cfg.unblocked ? '0 : ty5_reg;

        seq7_reg <= seq_wide[SEQ_BITS-1:0];
        off7_reg <= off6_reg[POFF_BITS-1:0];
        tx7_reg  <= tx6_reg[TILE_OUT_BITS-1:0];
        ty7_reg  <= ty6_reg[TILE_OUT_BITS-1:0];
    end

    assign done           = v7_reg;
    assign sequence_index = seq7_reg;
    assign pixel_offset   = off7_reg;
    assign tile_x         = tx7_reg;
    assign tile_y         = ty7_reg;

    a_offset_below_stride: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> (cfg.unblocked ? (off6_reg == '0)
                                  : (off6_reg < OFFSET_BITS'(cfg.stride))))
        else $error("pixel offset not below stride");

endmodule
